// ----- src/assert_macros.svh -----
// assertion macros used by the checker file nsc_checker.sv
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define NSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// next-cycle implication, disabled while reset is asserted
`define NSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ----- src/nsc_pkg.sv -----
// types, character codes and helper functions for the nmea sentence checker
// no dependencies
package nsc_pkg;

	// control characters and framing symbols
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	// hex digit ranges
	localparam logic [7:0] CH_DIGIT0  = 8'h30;
	localparam logic [7:0] CH_DIGIT9  = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;

	// marker returned for a byte that is not a hex digit
	localparam logic [4:0] HEX_NONE = 5'd16;

	// sentence type tags, first letter in the top byte
	localparam logic [23:0] TAG_RMC = 24'h524D43;
	localparam logic [23:0] TAG_GGA = 24'h474741;
	localparam logic [23:0] TAG_GSA = 24'h475341;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_RMC   = 2'd1,
		KIND_GGA   = 2'd2,
		KIND_GSA   = 2'd3
	} kind_t;

	// summary of one completed line
	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [6:0]  length;
		logic [7:0]  computed_sum;
		logic [7:0]  given_sum;
	} line_result_t;

	// digit value 0..15, or HEX_NONE
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] d;
		d = HEX_NONE;
		if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
			d = 5'(c - CH_DIGIT0);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
			d = 5'(c - CH_LOWER_A) + 5'd10;
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
			d = 5'(c - CH_UPPER_A) + 5'd10;
		end
		return d;
	endfunction

	function automatic kind_t classify(input logic [23:0] tag);
		kind_t k;
		if (tag == TAG_RMC) begin
			k = KIND_RMC;
		end else if (tag == TAG_GGA) begin
			k = KIND_GGA;
		end else if (tag == TAG_GSA) begin
			k = KIND_GSA;
		end else begin
			k = KIND_OTHER;
		end
		return k;
	endfunction

endpackage

// ----- src/nsc_framer.sv -----
// line state of the sentence checker: framing, checksum and hex parsing per byte
// depends on nsc_pkg
module nsc_framer import nsc_pkg::*; #(
	parameter int LINE_BYTES = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   char_in,
	output line_result_t summary
);

	localparam int POS_W = $clog2(LINE_BYTES);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] content_len_q, content_len_d;
	logic             zero_seen_q, zero_seen_d;
	logic             dollar_q, dollar_d;
	logic [7:0]       xor_q, xor_d;
	logic             star_q, star_d;
	logic [1:0]       after_star_q, after_star_d;
	logic [7:0]       hex_q, hex_d;
	logic             hex_open_q, hex_open_d;
	logic [23:0]      tag_q, tag_d;
	logic [4:0]       digit;

	assign digit = hex_digit(char_in);

	// next line state for the byte in the input stage
	always_comb begin
		pos_d         = pos_q;
		content_len_d = content_len_q;
		zero_seen_d   = zero_seen_q;
		dollar_d      = dollar_q;
		xor_d         = xor_q;
		star_d        = star_q;
		after_star_d  = after_star_q;
		hex_d         = hex_q;
		hex_open_d    = hex_open_q;
		tag_d         = tag_q;
		if (step) begin
			if (char_in == CH_LF || (char_in != CH_CR &&
					pos_q == POS_W'(LINE_BYTES - 1))) begin
				// end of line or overflow: back to an empty line
				pos_d         = '0;
				content_len_d = '0;
				zero_seen_d   = 1'b0;
				dollar_d      = 1'b0;
				xor_d         = '0;
				star_d        = 1'b0;
				after_star_d  = '0;
				hex_d         = '0;
				hex_open_d    = 1'b1;
				tag_d         = '0;
			end else if (char_in != CH_CR) begin
				pos_d = pos_q + POS_W'(1);
				if (!zero_seen_q) begin
					if (char_in == CH_NUL) begin
						zero_seen_d = 1'b1;
					end else begin
						content_len_d = pos_q + POS_W'(1);
						if (pos_q == '0 && char_in == CH_DOLLAR) begin
							dollar_d = 1'b1;
						end
						// type letters at positions 3 to 5
						if (pos_q == POS_W'(3)) begin
							tag_d[23:16] = tag_q[23:16] | char_in;
						end
						if (pos_q == POS_W'(4)) begin
							tag_d[15:8] = tag_q[15:8] | char_in;
						end
						if (pos_q == POS_W'(5)) begin
							tag_d[7:0] = tag_q[7:0] | char_in;
						end
						// checksum field after the star, running xor before it
						if (star_q) begin
							if (after_star_q != 2'd2) begin
								after_star_d = after_star_q + 2'd1;
							end
							if (hex_open_q) begin
								if (digit != HEX_NONE) begin
									hex_d = {hex_q[3:0], digit[3:0]};
								end else begin
									hex_open_d = 1'b0;
								end
							end
						end else if (char_in == CH_STAR) begin
							star_d = 1'b1;
						end else if (pos_q != '0) begin
							xor_d = xor_q ^ char_in;
						end
					end
				end
			end
		end
	end

	// line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			content_len_q <= '0;
			zero_seen_q   <= 1'b0;
			dollar_q      <= 1'b0;
			xor_q         <= '0;
			star_q        <= 1'b0;
			after_star_q  <= '0;
			hex_q         <= '0;
			hex_open_q    <= 1'b1;
			tag_q         <= '0;
		end else begin
			pos_q         <= pos_d;
			content_len_q <= content_len_d;
			zero_seen_q   <= zero_seen_d;
			dollar_q      <= dollar_d;
			xor_q         <= xor_d;
			star_q        <= star_d;
			after_star_q  <= after_star_d;
			hex_q         <= hex_d;
			hex_open_q    <= hex_open_d;
			tag_q         <= tag_d;
		end
	end

	// verdict for the line as it stands now
	always_comb begin
		summary.valid = content_len_q >= POS_W'(6) && dollar_q && star_q &&
			after_star_q == 2'd2 && xor_q == hex_q;
		summary.kind         = classify(tag_q);
		summary.length       = 7'(content_len_q);
		summary.computed_sum = xor_q;
		summary.given_sum    = hex_q;
	end

endmodule

// ----- src/nmea_sentence_checker.sv -----
// top level of the nmea sentence checker: input stage, line framer, result register
// depends on nsc_pkg and nsc_framer
//
//  channel | data                          | transaction when
//  --------+-------------------------------+------------------------------
//  input   | rx_byte                       | in_valid && !in_stall
//  output  | sentence_valid, sentence_kind,| out_valid && !out_stall
//          | line_length, computed_sum,    |
//          | given_sum                     |
//
// one byte per cycle while in_stall is low; a newline's result passes through the input
// stage into the result register and stays there until it is taken
// the line update is a single pass of logic between the input stage and the line state
// in_stall rises only when a newline waits in the input stage behind an untaken result
// reset clears the line state and both valid flags; no clearing pass is needed
module nmea_sentence_checker import nsc_pkg::*; #(
	parameter int LINE_BYTES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       sentence_valid,
	output logic [1:0] sentence_kind,
	output logic [6:0] line_length,
	output logic [7:0] computed_sum,
	output logic [7:0] given_sum
);

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         is_lf_s1;
	logic         blocked;
	logic         step;
	logic         out_valid_q;
	line_result_t result_q;
	line_result_t summary;

	// a newline cannot move on while the result register is full and stalled
	assign is_lf_s1 = char_s1 == CH_LF;
	assign blocked  = valid_s1 && is_lf_s1 && out_valid_q && out_stall;
	assign step     = valid_s1 && !blocked;
	assign in_stall = blocked;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!blocked) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !blocked) begin
			char_s1 <= rx_byte;
		end
	end

	nsc_framer #(
		.LINE_BYTES(LINE_BYTES)
	) u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.char_in (char_s1),
		.summary (summary)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && is_lf_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && is_lf_s1) begin
			result_q <= summary;
		end
	end

	assign out_valid      = out_valid_q;
	assign sentence_valid = result_q.valid;
	assign sentence_kind  = result_q.kind;
	assign line_length    = result_q.length;
	assign computed_sum   = result_q.computed_sum;
	assign given_sum      = result_q.given_sum;

endmodule

// ----- src/nsc_checker.sv -----
// port-level checks for the nmea sentence checker, bound to the top level
// depends on nsc_pkg and assert_macros.svh
`include "assert_macros.svh"

module nsc_checker import nsc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] rx_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic       sentence_valid,
	input logic [1:0] sentence_kind,
	input logic [6:0] line_length,
	input logic [7:0] computed_sum,
	input logic [7:0] given_sum
);

	logic [25:0] result_bits;
	logic        lf_taken;

	// result payload and newline transaction
	assign result_bits = {sentence_valid, sentence_kind, line_length, computed_sum, given_sum};
	assign lf_taken    = in_valid && !in_stall && rx_byte == CH_LF;

	// a stalled result holds
	`NSC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(result_bits))

	// the input side stalls only behind a full, stalled result register
	`NSC_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// a new result follows a newline transaction through the input stage and result register
	`NSC_ASSERT_IMP(a_result_source, clk, arst_n, $rose(out_valid), $past(lf_taken, 2))

	// a passing sentence carries matching sums
	`NSC_ASSERT_IMP(a_valid_sums, clk, arst_n, out_valid && sentence_valid, computed_sum == given_sum)

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (.*);

// ----- sim/nmea_sentence_checker_tb.sv -----
// self-checking testbench for nmea_sentence_checker: directed lines, then random lines
// depends on nsc_pkg and the checker rtl; predicts each line result and compares it field by field
module nmea_sentence_checker_tb;
	import nsc_pkg::*;

	localparam int LINE_BYTES = 128;
	localparam int STIM_BYTES = 1150;
	localparam int IDLE_PCT   = 16;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       sentence_valid;
	logic [1:0] sentence_kind;
	logic [6:0] line_length;
	logic [7:0] computed_sum;
	logic [7:0] given_sum;

	logic [7:0]   stim_bytes[$];
	line_result_t expected_lines[$];
	int           total_bytes;
	int           sent_bytes     = 0;
	int           accepted_bytes = 0;
	int           fail_count     = 0;
	logic         in_taken       = 1'b0;

	// predicted line state
	int          line_pos;
	int          stored_len;
	logic        nul_seen;
	logic        has_dollar;
	logic [7:0]  xor_sum;
	logic        star_seen;
	logic [1:0]  after_star;
	logic [7:0]  hex_acc;
	logic        hex_reading;
	logic [23:0] tag_bytes;

	// both sides run without idling over one stretch of the run
	wire quiet_run = sent_bytes >= 400 && sent_bytes < 750;

	nmea_sentence_checker dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.sentence_valid (sentence_valid),
		.sentence_kind  (sentence_kind),
		.line_length    (line_length),
		.computed_sum   (computed_sum),
		.given_sum      (given_sum)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// digit value 0..15, or -1 for a byte that is not hex
	function automatic int hex_value_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
		if (v < 4'd10) return CH_DIGIT0 + {4'h0, v};
		return (lower ? CH_LOWER_A : CH_UPPER_A) + {4'h0, v} - 8'd10;
	endfunction

	function automatic logic [7:0] rand_upper();
		return 8'($urandom_range(8'h5A, 8'h41));
	endfunction

	task automatic restart_line();
		line_pos    = 0;
		stored_len  = 0;
		nul_seen    = 1'b0;
		has_dollar  = 1'b0;
		xor_sum     = 8'h00;
		star_seen   = 1'b0;
		after_star  = 2'd0;
		hex_acc     = 8'h00;
		hex_reading = 1'b1;
		tag_bytes   = 24'h0;
	endtask

	// update the predicted line with one accepted byte; a newline queues a result
	task automatic predict_byte(input logic [7:0] c);
		line_result_t r;
		int d;
		if (c == CH_LF) begin
			r.valid = stored_len >= 6 && has_dollar && star_seen && after_star >= 2 &&
				xor_sum == hex_acc;
			if (tag_bytes == TAG_RMC) r.kind = KIND_RMC;
			else if (tag_bytes == TAG_GGA) r.kind = KIND_GGA;
			else if (tag_bytes == TAG_GSA) r.kind = KIND_GSA;
			else r.kind = KIND_OTHER;
			r.length       = stored_len[6:0];
			r.computed_sum = xor_sum;
			r.given_sum    = hex_acc;
			expected_lines.push_back(r);
			restart_line();
		end else if (c == CH_CR) begin
			// carriage return leaves the line untouched
		end else if (line_pos >= LINE_BYTES - 1) begin
			restart_line();
		end else begin
			if (!nul_seen) begin
				if (c == CH_NUL) begin
					nul_seen = 1'b1;
				end else begin
					if (line_pos == 0 && c == CH_DOLLAR) has_dollar = 1'b1;
					if (line_pos >= 3 && line_pos <= 5) tag_bytes[8 * (5 - line_pos) +: 8] = c;
					if (star_seen) begin
						if (after_star < 2) after_star++;
						if (hex_reading) begin
							d = hex_value_of(c);
							if (d >= 0) hex_acc = {hex_acc[3:0], 4'(d)};
							else hex_reading = 1'b0;
						end
					end else if (c == CH_STAR) begin
						star_seen = 1'b1;
					end else if (line_pos >= 1) begin
						xor_sum ^= c;
					end
					stored_len = line_pos + 1;
				end
			end
			line_pos++;
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			fail_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) stim_bytes.push_back(s[i]);
	endtask

	// well-formed sentence with random content, sometimes broken on purpose
	task automatic add_sentence();
		logic [7:0]  ln[$];
		logic [7:0]  c;
		logic [7:0]  sum;
		logic [23:0] tag;
		bit          lc;
		int          mut;
		lc  = 1'($urandom_range(1));
		mut = $urandom_range(19);
		case ($urandom_range(3))
			0: tag = TAG_RMC;
			1: tag = TAG_GGA;
			2: tag = TAG_GSA;
			default: tag = {rand_upper(), rand_upper(), rand_upper()};
		endcase
		ln.push_back(CH_DOLLAR);
		ln.push_back(rand_upper());
		ln.push_back(rand_upper());
		ln.push_back(tag[23:16]);
		ln.push_back(tag[15:8]);
		ln.push_back(tag[7:0]);
		repeat ($urandom_range(12)) begin
			do c = 8'($urandom_range(8'h7E, 8'h20)); while (c == CH_STAR);
			ln.push_back(c);
		end
		sum = 8'h00;
		for (int i = 1; i < ln.size(); i++) sum ^= ln[i];
		// wrong checksum
		if (mut == 0) sum ^= 8'($urandom_range(255, 1));
		// missing star leaves no checksum at all
		if (mut != 1) begin
			ln.push_back(CH_STAR);
			if (mut == 5) ln.push_back(hex_char(4'($urandom), lc));
			ln.push_back(hex_char(sum[7:4], lc));
			if (mut != 2) ln.push_back(hex_char(sum[3:0], lc));
			if (mut == 6) begin
				ln.push_back(8'h2C);
				ln.push_back(8'($urandom_range(8'h7E, 8'h20)));
			end
		end
		if (mut == 3) ln[0] = 8'($urandom_range(255));
		if (mut == 4) ln.insert($urandom_range(ln.size()), CH_NUL);
		if ($urandom_range(1)) ln.push_back(CH_CR);
		ln.push_back(CH_LF);
		foreach (ln[i]) stim_bytes.push_back(ln[i]);
	endtask

	// driver: new byte only once the last one was taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (stim_bytes.size() != 0 && (quiet_run || $urandom_range(99) >= IDLE_PCT)) begin
					in_valid   <= 1'b1;
					rx_byte    <= stim_bytes.pop_front();
					sent_bytes <= sent_bytes + 1;
				end else begin
					in_valid <= 1'b0;
					rx_byte  <= 8'($urandom);
				end
			end
			out_stall <= !quiet_run && $urandom_range(99) < IDLE_PCT;
		end
	end

	// monitor: check result transactions, predict from input transactions
	always @(posedge clk) begin
		line_result_t want;
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_lines.size() == 0) begin
				fail_count++;
				$error("result transaction with no line pending");
			end else begin
				want = expected_lines.pop_front();
				check_field("sentence_valid", 8'(want.valid), 8'(sentence_valid));
				check_field("sentence_kind", 8'(want.kind), 8'(sentence_kind));
				check_field("line_length", 8'(want.length), 8'(line_length));
				check_field("computed_sum", want.computed_sum, computed_sum);
				check_field("given_sum", want.given_sum, given_sum);
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			accepted_bytes++;
			predict_byte(rx_byte);
		end
	end

	initial begin
		int sel;
		restart_line();

		// directed: empty line, clean GGA, star first with 0xff and a zero byte,
		// RMC with a single byte after the star
		add_text("\n");
		add_text("$GPGGA*56\r\n");
		stim_bytes.push_back(CH_STAR);
		stim_bytes.push_back(8'hFF);
		stim_bytes.push_back(CH_NUL);
		stim_bytes.push_back(8'hAB);
		stim_bytes.push_back(CH_LF);
		add_text("$GNRMC*0\n");

		// random lines
		while (stim_bytes.size() < STIM_BYTES) begin
			sel = $urandom_range(99);
			if (sel < 70) begin
				add_sentence();
			end else if (sel < 86) begin
				repeat ($urandom_range(12)) stim_bytes.push_back(8'($urandom));
				stim_bytes.push_back(CH_LF);
			end else if (sel < 91) begin
				// lines around the overflow boundary
				stim_bytes.push_back(CH_DOLLAR);
				repeat ($urandom_range(131, 124)) stim_bytes.push_back(8'($urandom_range(8'h7E, 8'h20)));
				stim_bytes.push_back(CH_LF);
			end else begin
				if ($urandom_range(1)) stim_bytes.push_back(CH_CR);
				stim_bytes.push_back(CH_LF);
			end
		end
		total_bytes = stim_bytes.size();

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		while (accepted_bytes != total_bytes || expected_lines.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
